FILE: rtl/core/csb_pkg.sv
// Package for the calendar seconds-between block.
// Holds the item and result structs, the internal classified-item types, widths,
// constants and the month offset table. It depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package csb_pkg;

  // Field widths of one input item and one result.
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int OUT_W   = 39;

  // Internal widths.
  localparam int Q_W    = 8;   // year / 100 for a 14-bit year
  localparam int DAYS_W = 24;  // signed day count from the epoch
  localparam int TOD_W  = 17;  // seconds within one (unchecked) day
  localparam int PROD_W = 40;  // signed day count times seconds per day
  localparam int DIFF_W = 42;  // signed difference before saturation

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Divide by 100 as a multiply by a reciprocal, exact for values below 43690.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  // Days from year 0 to 2000-01-01.
  localparam logic [DAYS_W-1:0] EPOCH_DAYS = 24'd730485;

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
  localparam logic signed [PROD_W-1:0] SEC_PER_DAY = 40'sd86400;

  // Saturation bounds of the result.
  localparam logic signed [DIFF_W-1:0] OUT_MAX = (42'sd1 <<< (OUT_W - 1)) - 42'sd1;
  localparam logic signed [DIFF_W-1:0] OUT_MIN = -(42'sd1 <<< (OUT_W - 1));

  // Month codes.
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // One input item.
  typedef struct packed {
    logic [YEAR_W-1:0]  from_year;
    logic [MONTH_W-1:0] from_month;
    logic [DAY_W-1:0]   from_day;
    logic [HOUR_W-1:0]  from_hour;
    logic [MIN_W-1:0]   from_minute;
    logic [SEC_W-1:0]   from_second;
    logic [YEAR_W-1:0]  to_year;
    logic [MONTH_W-1:0] to_month;
    logic [DAY_W-1:0]   to_day;
    logic [HOUR_W-1:0]  to_hour;
    logic [MIN_W-1:0]   to_minute;
    logic [SEC_W-1:0]   to_second;
  } in_t;

  // One result.
  typedef struct packed {
    logic signed [OUT_W-1:0] seconds_between;
    logic                    month_error;
  } out_t;

  // One date-time after classification by the front.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [Q_W-1:0]     q100;   // year / 100
    logic               r_nz;   // year not a multiple of 100
    logic               leap;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } side_t;

  // One classified item as it sits in the queue.
  typedef struct packed {
    logic  month_error;
    side_t from_side;
    side_t to_side;
  } cls_t;

  // Queue status seen by front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Days in the year before the first of the given month.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/calendar_seconds_between_top.sv
// An item reaches done via the front register, a queue slot and the three back stages.
// Throughput: one item per cycle; the front register, one queue slot and the
// three back stages each hold one item, and the back drains the queue every cycle.
// Reset (rst, synchronous): clears all valid flags and queue pointers; busy is high
// while rst is high. The receiver cannot stall: each result shows for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module calendar_seconds_between_top #(
  parameter int QUEUE_DEPTH = csb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire csb_pkg::in_t  req,
  output logic               busy,
  output logic               done,
  output csb_pkg::out_t      rsp
);

  logic             q_push;
  logic             q_pop;
  csb_pkg::cls_t    q_push_data;
  csb_pkg::cls_t    q_pop_data;
  csb_pkg::q_stat_t q_stat;

  // Front: accept and classify.
  csb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .stat      (q_stat),
    .busy      (busy),
    .push      (q_push),
    .push_data (q_push_data)
  );

  // Queue between front and back.
  csb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  // Back: compute and deliver.
  csb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .stat     (q_stat),
    .pop_data (q_pop_data),
    .pop      (q_pop),
    .done     (done),
    .rsp      (rsp)
  );

  // Every accepted item yields its result after a fixed latency.
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted item did not produce a result on time");

  // The back drains the queue every cycle, so it never fills.
  a_queue_never_full: assert property (@(posedge clk) disable iff (rst)
    !q_stat.full)
    else $error("queue filled up");

  // A result comes from an item that sat in the queue before passing the back stages.
  a_result_from_queue: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(!q_stat.empty, 3))
    else $error("result without a queued item");

  // A month error always comes with a zero difference.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.month_error) |-> (rsp.seconds_between == '0))
    else $error("month error with nonzero difference");

endmodule

`default_nettype wire

FILE: rtl/core/csb_front.sv
// Front of the calendar seconds-between block: accepts items and classifies them.
// Checks both months and derives year / 100 and the leap flag. Uses csb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csb_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire csb_pkg::in_t   req,
  input  wire csb_pkg::q_stat_t stat,
  output logic                busy,
  output logic                push,
  output csb_pkg::cls_t       push_data
);

  logic          f_valid;
  csb_pkg::cls_t f_data;
  csb_pkg::cls_t f_data_next;

  // Split a date-time into its fields and work out the century terms.
  function automatic csb_pkg::side_t classify(
    input logic [csb_pkg::YEAR_W-1:0]  y,
    input logic [csb_pkg::MONTH_W-1:0] m,
    input logic [csb_pkg::DAY_W-1:0]   d,
    input logic [csb_pkg::HOUR_W-1:0]  h,
    input logic [csb_pkg::MIN_W-1:0]   mi,
    input logic [csb_pkg::SEC_W-1:0]   s
  );
    csb_pkg::side_t            r;
    logic [26:0]               prod;
    logic [csb_pkg::Q_W-1:0]   q;
    logic [csb_pkg::YEAR_W-1:0] hund;
    prod = 27'(y) * 27'(csb_pkg::DIV100_MUL);
    q    = csb_pkg::Q_W'(prod >> csb_pkg::DIV100_SHIFT);
    hund = csb_pkg::YEAR_W'(14'(q) * 14'd100);
    r.year   = y;
    r.q100   = q;
    r.r_nz   = (y != hund);
    r.leap   = ((y[1:0] == 2'd0) && r.r_nz) || (!r.r_nz && (q[1:0] == 2'd0));
    r.month  = m;
    r.day    = d;
    r.hour   = h;
    r.minute = mi;
    r.second = s;
    return r;
  endfunction

  function automatic logic month_bad(input logic [csb_pkg::MONTH_W-1:0] m);
    return (m == '0) || (m > csb_pkg::MONTH_DEC);
  endfunction

  // The front holds only while its item cannot enter a full queue.
  assign busy = rst || (f_valid && stat.full);
  assign push = f_valid && !stat.full;
  assign push_data = f_data;

  // Classification of the item on the request port.
  always_comb begin
    f_data_next.month_error = month_bad(req.from_month) || month_bad(req.to_month);
    f_data_next.from_side = classify(req.from_year, req.from_month, req.from_day,
                                     req.from_hour, req.from_minute, req.from_second);
    f_data_next.to_side = classify(req.to_year, req.to_month, req.to_day,
                                   req.to_hour, req.to_minute, req.to_second);
  end

  // Front register.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!busy) begin
      f_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      f_data <= f_data_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/csb_queue.sv
// Short queue of classified items between the front and back of the block.
// A register array with read and write pointers and a fill count. Uses csb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csb_queue #(
  parameter int DEPTH = csb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire csb_pkg::cls_t   push_data,
  input  wire logic            pop,
  output csb_pkg::cls_t        pop_data,
  output csb_pkg::q_stat_t     stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  csb_pkg::cls_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/csb_back.sv
// Back of the calendar seconds-between block: a three-stage pipeline that turns
// classified items into day counts, seconds and the saturated difference. Uses csb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csb_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire csb_pkg::q_stat_t stat,
  input  wire csb_pkg::cls_t    pop_data,
  output logic                  pop,
  output logic                  done,
  output csb_pkg::out_t         rsp
);

  // Stage 1 registers: day counts and time of day.
  logic                                v1;
  logic                                err1;
  logic signed [csb_pkg::DAYS_W-1:0]   from_days;
  logic signed [csb_pkg::DAYS_W-1:0]   to_days;
  logic [csb_pkg::TOD_W-1:0]           from_tod1;
  logic [csb_pkg::TOD_W-1:0]           to_tod1;

  // Stage 2 registers: day counts in seconds.
  logic                                v2;
  logic                                err2;
  logic signed [csb_pkg::PROD_W-1:0]   from_prod;
  logic signed [csb_pkg::PROD_W-1:0]   to_prod;
  logic [csb_pkg::TOD_W-1:0]           from_tod2;
  logic [csb_pkg::TOD_W-1:0]           to_tod2;

  logic signed [csb_pkg::DIFF_W-1:0]   diff;
  logic signed [csb_pkg::DIFF_W-1:0]   sat;

  // Signed days from 2000-01-01 to the given date.
  function automatic logic signed [csb_pkg::DAYS_W-1:0] day_count(input csb_pkg::side_t s);
    logic [14:0] y3;
    logic [23:0] pos;
    logic [23:0] neg;
    logic [8:0]  q_ceil;
    logic [6:0]  q4_ceil;
    logic        late_leap;
    y3        = {1'b0, s.year} + 15'd3;
    q_ceil    = {1'b0, s.q100} + 9'(s.r_nz);
    q4_ceil   = {1'b0, s.q100[7:2]} + 7'(s.r_nz || (s.q100[1:0] != 2'd0));
    late_leap = s.leap && (s.month > csb_pkg::MONTH_FEB);
    pos = 24'(s.year) * 24'(csb_pkg::DAYS_PER_YEAR) + 24'(y3[14:2]) + 24'(q4_ceil)
        + 24'(csb_pkg::days_before_month(s.month)) + 24'(late_leap) + 24'(s.day);
    neg = 24'(q_ceil) + csb_pkg::EPOCH_DAYS + 24'd1;
    return csb_pkg::DAYS_W'($signed({1'b0, pos}) - $signed({1'b0, neg}));
  endfunction

  // Seconds within the day, with no range checks.
  function automatic logic [csb_pkg::TOD_W-1:0] time_of_day(input csb_pkg::side_t s);
    return csb_pkg::TOD_W'(17'(s.hour) * 17'(csb_pkg::SEC_PER_HOUR)
                         + 17'(s.minute) * 17'(csb_pkg::SEC_PER_MIN) + 17'(s.second));
  endfunction

  // The back never stalls, so every queued item is taken at once.
  assign pop = !stat.empty;

  // Stage 1: day counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= pop;
    end
  end

  always_ff @(posedge clk) begin
    err1      <= pop_data.month_error;
    from_days <= day_count(pop_data.from_side);
    to_days   <= day_count(pop_data.to_side);
    from_tod1 <= time_of_day(pop_data.from_side);
    to_tod1   <= time_of_day(pop_data.to_side);
  end

  // Stage 2: scale days to seconds.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    err2      <= err1;
    from_prod <= csb_pkg::PROD_W'(from_days) * csb_pkg::SEC_PER_DAY;
    to_prod   <= csb_pkg::PROD_W'(to_days) * csb_pkg::SEC_PER_DAY;
    from_tod2 <= from_tod1;
    to_tod2   <= to_tod1;
  end

  // Stage 3: difference, saturation and the month error override.
  always_comb begin
    diff = (csb_pkg::DIFF_W'(to_prod) + $signed({25'd0, to_tod2}))
         - (csb_pkg::DIFF_W'(from_prod) + $signed({25'd0, from_tod2}));
    if (diff > csb_pkg::OUT_MAX) begin
      sat = csb_pkg::OUT_MAX;
    end else if (diff < csb_pkg::OUT_MIN) begin
      sat = csb_pkg::OUT_MIN;
    end else begin
      sat = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    rsp.month_error     <= err2;
    rsp.seconds_between <= err2 ? '0 : csb_pkg::OUT_W'(sat);
  end

endmodule

`default_nettype wire
